/* design/notification_led_pattern_arbiter_defines.svh */
// assertion helpers for the checker file
`ifndef NOTIFICATION_LED_PATTERN_ARBITER_DEFINES_SVH
`define NOTIFICATION_LED_PATTERN_ARBITER_DEFINES_SVH

// same-cycle implication
`define NLPA_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define NLPA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

/* design/nlpa_pkg.sv */
package nlpa_pkg;

   // slot codes
   localparam logic [1:0] SLOT_BATTERY   = 2'd0;
   localparam logic [1:0] SLOT_NOTIFY    = 2'd1;
   localparam logic [1:0] SLOT_ATTENTION = 2'd2;
   // cmd code that names no slot; nothing is stored for it
   localparam logic [1:0] SLOT_UNUSED    = 2'd3;
   localparam int         SLOT_COUNT     = 3;

   localparam int         RAMP_STEPS_DEF  = 8;
   localparam int         RAMP_TABLE_LEN  = 8;
   localparam int         RAMP_IDX_W      = 3;
   localparam int         DUTY_BITS       = 7;
   localparam int         DUTY_W          = 56;
   localparam int         QUEUE_DEPTH_DEF = 2;
   localparam logic [7:0] RAMP_STEP_RESET = 8'd50;
   localparam logic [7:0] ALPHA_FULL      = 8'hff;

   // luma weights
   localparam logic [7:0] LUMA_R = 8'd77;
   localparam logic [7:0] LUMA_G = 8'd150;
   localparam logic [7:0] LUMA_B = 8'd29;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] color;
      logic        flash_timed;
      logic [15:0] on_ms;
      logic [15:0] off_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]        source_shown;
      logic              blink_enable;
      logic [7:0]        white_level;
      logic [DUTY_W-1:0] duty_ramp;
      logic [15:0]       pause_low_ms;
      logic [15:0]       pause_high_ms;
      logic [7:0]        step_ms;
   } rsp_type;

   // classified update handed from front to back
   typedef struct packed {
      logic [1:0]  source;
      logic [23:0] rgb;
      logic [15:0] on_time;
      logic [15:0] off_time;
   } cls_type;

   // exact x/255 for products of two bytes
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return s[15:8];
   endfunction

   function automatic logic [6:0] ramp_value(input logic [RAMP_IDX_W-1:0] idx);
      logic [6:0] v;
      case (idx)
         3'd0: v = 7'd0;
         3'd1: v = 7'd12;
         3'd2: v = 7'd25;
         3'd3: v = 7'd37;
         3'd4: v = 7'd50;
         3'd5: v = 7'd72;
         3'd6: v = 7'd85;
         3'd7: v = 7'd100;
         default: v = 7'd0;
      endcase
      return v;
   endfunction

endpackage

/* design/notification_led_pattern_arbiter.sv */
// channel     | ports                               | transfer when
// ------------+-------------------------------------+------------------------
// update in   | push, full, req_data                | push && !full
// result out  | pop, empty, rsp_data                | pop && !empty
// step config | csr_write_en, csr_write_data        | csr_write_en
//
// front: capture, alpha multiply, slot store, select for each update
// back: takes the entry, computes luma, runs the two-step duty ramp loop, which sets
// the pace, and then loads the output register
// reset is synchronous; slots clear to zero and the step register to 50 ms
// a held result stalls only the back; the queue lets the front keep going
module notification_led_pattern_arbiter import nlpa_pkg::*; #(
   parameter int RAMP_STEPS  = RAMP_STEPS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  req_type    req_data,
   output logic       empty,
   input  logic       pop,
   output rsp_type    rsp_data,
   input  logic       csr_write_en,
   input  logic [7:0] csr_write_data
);

   // classified updates between front and back
   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   cls_type q_wr_data;
   cls_type q_rd_data;

   // front: alpha scaling, slot store and source pick
   nlpa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_data   (q_wr_data)
   );

   // short queue so either side can stall alone
   nlpa_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .full    (q_full),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_data (q_rd_data)
   );

   // back: luma, duty ramp, pause and step timing, result register
   nlpa_back #(
      .RAMP_STEPS (RAMP_STEPS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .q_data         (q_rd_data),
      .empty          (empty),
      .pop            (pop),
      .rsp_data       (rsp_data)
   );

endmodule

/* design/nlpa_front.sv */
module nlpa_front import nlpa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    q_push,
   input  logic    q_full,
   output cls_type q_data
);

   typedef enum logic [3:0] {
      F_IDLE  = 4'b0001,
      F_MUL   = 4'b0010,
      F_STORE = 4'b0100,
      F_SEL   = 4'b1000
   } front_state_type;

   front_state_type state_ff, state_in;
   req_type         item_ff;
   logic [15:0]     prod_ff [3];
   logic [15:0]     prod_in [3];

   logic [23:0] slot_rgb_ff      [SLOT_COUNT];
   logic        slot_timed_ff    [SLOT_COUNT];
   logic [15:0] slot_on_time_ff  [SLOT_COUNT];
   logic [15:0] slot_off_time_ff [SLOT_COUNT];

   logic [7:0]  alpha;
   logic        do_scale;
   logic [23:0] store_rgb;
   logic [1:0]  sel;

   assign alpha    = item_ff.color[31:24];
   assign do_scale = (item_ff.cmd == SLOT_NOTIFY) && (alpha != 8'd0) && (alpha != ALPHA_FULL);
   assign full     = (state_ff != F_IDLE);

   // channel times alpha
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod_in[c] = 16'(item_ff.color[c*8 +: 8]) * 16'(alpha);
      end
   end

   always_comb begin
      store_rgb = item_ff.color[23:0];
      if (do_scale) begin
         for (int c = 0; c < 3; c++) begin
            store_rgb[c*8 +: 8] = div255(prod_ff[c]);
         end
      end
   end

   // attention over notification over battery
   always_comb begin
      if (slot_rgb_ff[SLOT_ATTENTION] != 24'd0) begin
         sel = SLOT_ATTENTION;
      end else if (slot_rgb_ff[SLOT_NOTIFY] != 24'd0) begin
         sel = SLOT_NOTIFY;
      end else begin
         sel = SLOT_BATTERY;
      end
   end

   always_comb begin
      q_data.source   = sel;
      q_data.rgb      = slot_rgb_ff[sel];
      q_data.on_time  = slot_timed_ff[sel] ? slot_on_time_ff[sel] : 16'd0;
      q_data.off_time = slot_timed_ff[sel] ? slot_off_time_ff[sel] : 16'd0;
   end

   assign q_push = (state_ff == F_SEL) && !q_full;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE:  if (push) state_in = F_MUL;
         F_MUL:   state_in = F_STORE;
         F_STORE: state_in = F_SEL;
         F_SEL:   if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && push) begin
         item_ff <= req_data;
      end
      if (state_ff == F_MUL) begin
         prod_ff <= prod_in;
      end
   end

   // slot store, unused code writes nothing
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_rgb_ff[s]      <= 24'd0;
            slot_timed_ff[s]    <= 1'b0;
            slot_on_time_ff[s]  <= 16'd0;
            slot_off_time_ff[s] <= 16'd0;
         end
      end else if (state_ff == F_STORE && item_ff.cmd != SLOT_UNUSED) begin
         slot_rgb_ff[item_ff.cmd]      <= store_rgb;
         slot_timed_ff[item_ff.cmd]    <= item_ff.flash_timed;
         slot_on_time_ff[item_ff.cmd]  <= item_ff.on_ms;
         slot_off_time_ff[item_ff.cmd] <= item_ff.off_ms;
      end
   end

endmodule

/* design/nlpa_queue.sv */
module nlpa_queue import nlpa_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  cls_type wr_data,
   input  logic    pop,
   output logic    empty,
   output cls_type rd_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cls_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* design/nlpa_back.sv */
module nlpa_back import nlpa_pkg::*; #(
   parameter int RAMP_STEPS = RAMP_STEPS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic [7:0] csr_write_data,
   input  logic       q_empty,
   output logic       q_pop,
   input  cls_type    q_data,
   output logic       empty,
   input  logic       pop,
   output rsp_type    rsp_data
);

   localparam int RAMP_PAIRS = (RAMP_STEPS + 1) / 2;
   localparam int CNT_W      = (RAMP_PAIRS > 1) ? $clog2(RAMP_PAIRS) : 1;
   localparam int DIV_D      = 2 * RAMP_STEPS;
   localparam int DIV_S      = 16 + $clog2(DIV_D);
   localparam int PROD_W     = 16 + DIV_S + 1;
   localparam int SPAN_W     = 8 + $clog2(DIV_D + 1);
   // reciprocal of twice the step count, rounded up so the shift is exact on 16 bits
   localparam logic [DIV_S:0] DIV_M = (DIV_S + 1)'((2 ** DIV_S) / DIV_D + 1);

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_LUMA = 4'b0010,
      B_RAMP = 4'b0100,
      B_DONE = 4'b1000
   } back_state_type;

   back_state_type     state_ff, state_in;
   cls_type            ent_ff;
   logic [7:0]         ramp_step_ff;
   logic [7:0]         white_ff, white_in;
   logic               blink_ff, blink_in;
   logic [SPAN_W-1:0]  span_ff, span_in;
   logic [PROD_W-1:0]  qprod_ff, qprod_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DUTY_W-1:0]  duty_ff, duty_in;
   logic               last_pair;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff;
   logic               load_rsp;
   logic [15:0]        luma_sum;
   logic               clamped;

   assign empty     = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign q_pop     = (state_ff == B_IDLE) && !q_empty;
   assign last_pair = (cnt_ff == CNT_W'(RAMP_PAIRS - 1));
   assign load_rsp  = (state_ff == B_DONE) && (!rsp_valid_ff || pop);

   // luma, blink decision, ramp span and quotient product
   always_comb begin
      luma_sum = 16'(ent_ff.rgb[23:16]) * 16'(LUMA_R)
               + 16'(ent_ff.rgb[15:8]) * 16'(LUMA_G)
               + 16'(ent_ff.rgb[7:0]) * 16'(LUMA_B);
      white_in = luma_sum[15:8];
      blink_in = (ent_ff.on_time != 16'd0) && (ent_ff.off_time != 16'd0);
      span_in  = SPAN_W'(ramp_step_ff) * SPAN_W'(DIV_D);
      qprod_in = PROD_W'(ent_ff.on_time) * PROD_W'(DIV_M);
   end

   // two ramp steps per cycle
   always_comb begin
      logic [RAMP_IDX_W-1:0] idx;
      logic [15:0]           prod;
      duty_in = duty_ff;
      for (int j = 0; j < 2; j++) begin
         idx  = RAMP_IDX_W'({cnt_ff, 1'(j)});
         prod = 16'(ramp_value(idx)) * 16'(white_ff);
         if (int'(idx) < RAMP_STEPS) begin
            duty_in[int'(idx)*DUTY_BITS +: DUTY_BITS] = DUTY_BITS'(div255(prod));
         end
      end
   end

   always_comb begin
      clamped = 16'(span_ff) > ent_ff.on_time;
      rsp_in  = '0;
      rsp_in.source_shown = ent_ff.source;
      rsp_in.blink_enable = blink_ff;
      rsp_in.white_level  = white_ff;
      if (blink_ff) begin
         rsp_in.duty_ramp     = duty_ff;
         rsp_in.pause_low_ms  = ent_ff.off_time;
         rsp_in.pause_high_ms = clamped ? 16'd0 : ent_ff.on_time - 16'(span_ff);
         rsp_in.step_ms       = clamped ? qprod_ff[DIV_S +: 8] : ramp_step_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:  if (!q_empty) state_in = B_LUMA;
         B_LUMA:  state_in = B_RAMP;
         B_RAMP:  if (last_pair) state_in = B_DONE;
         B_DONE:  if (load_rsp) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         ramp_step_ff <= RAMP_STEP_RESET;
         cnt_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            ramp_step_ff <= csr_write_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (pop) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == B_RAMP) begin
            cnt_ff <= last_pair ? '0 : cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         ent_ff  <= q_data;
         duty_ff <= '0;
      end
      if (state_ff == B_LUMA) begin
         white_ff <= white_in;
         blink_ff <= blink_in;
         span_ff  <= span_in;
         qprod_ff <= qprod_in;
      end
      if (state_ff == B_RAMP) begin
         duty_ff <= duty_in;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* design/nlpa_checker.sv */
`include "notification_led_pattern_arbiter_defines.svh"

module nlpa_checker import nlpa_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       push,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input rsp_type    rsp_data
);

   // nothing waits right after reset
   `NLPA_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, empty)

   // a waiting result holds until taken
   `NLPA_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_data))

   // an accepted update keeps the front busy the next cycle
   `NLPA_ASSERT_NEXT(a_front_busy, clock, reset, push && !full, full)

   // timing fields are quiet unless blinking
   `NLPA_ASSERT_IMPLY(a_quiet, clock, reset, !empty && !rsp_data.blink_enable,
      rsp_data.duty_ramp == '0 && rsp_data.pause_low_ms == 16'd0
      && rsp_data.pause_high_ms == 16'd0 && rsp_data.step_ms == 8'd0)

endmodule

bind notification_led_pattern_arbiter nlpa_checker u_nlpa_checker (
   .clock          (clock),
   .reset          (reset),
   .push           (push),
   .full           (full),
   .empty          (empty),
   .pop            (pop),
   .rsp_data       (rsp_data)
);

/* tb/sv/nlpa_result_check.sv */
`timescale 1ns / 100ps

module nlpa_result_check import nlpa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic       full,
   input  req_type    req_data,
   input  logic       empty,
   input  logic       pop,
   input  rsp_type    rsp_data,
   input  logic       csr_write_en,
   input  logic [7:0] csr_write_data,
   input  logic       drained,
   output int         fail_count,
   output int         results_checked,
   output int         blinks_checked
);

   // duty ramp levels, step 0 in the low bits
   localparam logic [55:0] RAMP_LEVELS = {7'd100, 7'd85, 7'd72, 7'd50,
                                          7'd37, 7'd25, 7'd12, 7'd0};
   localparam int MAX_REPORTS = 100;

   logic [23:0] lit_rgb   [SLOT_COUNT];
   logic        lit_timed [SLOT_COUNT];
   logic [15:0] lit_on    [SLOT_COUNT];
   logic [15:0] lit_off   [SLOT_COUNT];
   logic [7:0]  step_setting;
   rsp_type     light_results [$];
   bit          leftover_done;

   // store the update, then derive the light the block should show
   function automatic rsp_type predict_light(input req_type u);
      rsp_type    r;
      logic [23:0] rgb;
      logic [7:0]  alpha;
      int          shown, white, on_t, off_t, span;
      r = '0;
      rgb = u.color[23:0];
      alpha = u.color[31:24];
      if (u.cmd == SLOT_NOTIFY && alpha != 8'h00 && alpha != ALPHA_FULL) begin
         for (int k = 0; k < 3; k++)
            rgb[8*k +: 8] = 8'((int'(rgb[8*k +: 8]) * int'(alpha)) / 255);
      end
      if (u.cmd <= SLOT_ATTENTION) begin
         lit_rgb[u.cmd]   = rgb;
         lit_timed[u.cmd] = u.flash_timed;
         lit_on[u.cmd]    = u.on_ms;
         lit_off[u.cmd]   = u.off_ms;
      end
      if (lit_rgb[SLOT_ATTENTION] != '0)
         shown = int'(SLOT_ATTENTION);
      else if (lit_rgb[SLOT_NOTIFY] != '0)
         shown = int'(SLOT_NOTIFY);
      else
         shown = int'(SLOT_BATTERY);
      white = (77 * int'(lit_rgb[shown][23:16]) + 150 * int'(lit_rgb[shown][15:8])
               + 29 * int'(lit_rgb[shown][7:0])) >> 8;
      on_t  = lit_timed[shown] ? int'(lit_on[shown]) : 0;
      off_t = lit_timed[shown] ? int'(lit_off[shown]) : 0;
      r.source_shown = 2'(shown);
      r.white_level  = 8'(white);
      r.blink_enable = (on_t > 0 && off_t > 0);
      if (r.blink_enable) begin
         span = int'(step_setting) * RAMP_STEPS_DEF * 2;
         if (span > on_t) begin
            r.step_ms       = 8'(on_t / (RAMP_STEPS_DEF * 2));
            r.pause_high_ms = '0;
         end else begin
            r.step_ms       = step_setting;
            r.pause_high_ms = 16'(on_t - span);
         end
         r.pause_low_ms = 16'(off_t);
         for (int k = 0; k < RAMP_STEPS_DEF; k++)
            r.duty_ramp[7*k +: 7] = 7'((int'(RAMP_LEVELS[7*k +: 7]) * white) / 255);
      end
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         if (fail_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int k = 0; k < SLOT_COUNT; k++) begin
            lit_rgb[k]   = '0;
            lit_timed[k] = 1'b0;
            lit_on[k]    = '0;
            lit_off[k]   = '0;
         end
         step_setting = RAMP_STEP_RESET;
         light_results.delete();
         leftover_done   = 1'b0;
         fail_count      = 0;
         results_checked = 0;
         blinks_checked  = 0;
      end else begin
         // result side first, an update taken this edge cannot already be out
         if (pop && !empty) begin
            results_checked++;
            if (rsp_data.blink_enable)
               blinks_checked++;
            if (light_results.size() == 0) begin
               $display("%0t: result transfer with nothing expected, expected none, got 0x%0h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               want = light_results.pop_front();
               compare_field("source_shown", 64'(want.source_shown),
                             64'(rsp_data.source_shown));
               compare_field("blink_enable", 64'(want.blink_enable),
                             64'(rsp_data.blink_enable));
               compare_field("white_level", 64'(want.white_level),
                             64'(rsp_data.white_level));
               compare_field("duty_ramp", 64'(want.duty_ramp),
                             64'(rsp_data.duty_ramp));
               compare_field("pause_low_ms", 64'(want.pause_low_ms),
                             64'(rsp_data.pause_low_ms));
               compare_field("pause_high_ms", 64'(want.pause_high_ms),
                             64'(rsp_data.pause_high_ms));
               compare_field("step_ms", 64'(want.step_ms),
                             64'(rsp_data.step_ms));
            end
         end
         if (push && !full)
            light_results.push_back(predict_light(req_data));
         if (csr_write_en)
            step_setting = csr_write_data;
         if (drained && !leftover_done) begin
            leftover_done = 1'b1;
            if (light_results.size() != 0) begin
               $display("%0t: %0d results never arrived, expected 0 outstanding, got %0d",
                        $time, light_results.size(), light_results.size());
               fail_count += light_results.size();
            end
         end
      end
   end

endmodule

/* tb/sv/tb_notification_led_pattern_arbiter.sv */
`timescale 1ns / 100ps

module tb_notification_led_pattern_arbiter;
   import nlpa_pkg::*;

   localparam int UPDATES_PER_SETTING = 250;
   localparam int CYCLE_LIMIT = 1000000;
   // a little more than front plus back latency
   localparam int DRAIN_CYCLES = 20;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       pop = 1'b0;
   logic       csr_write_en = 1'b0;
   logic [7:0] csr_write_data = '0;
   logic       drained = 1'b0;
   req_type    req_data = '0;
   logic       full;
   logic       empty;
   rsp_type    rsp_data;

   int fail_count;
   int results_checked;
   int blinks_checked;
   int updates_sent = 0;
   int directed_count = 0;
   int settings_count = 0;
   int cycle_count = 0;
   int send_quiet = 0;
   int rsp_quiet = 0;
   int rsp_stall = 0;
   logic [7:0] step_now = RAMP_STEP_RESET;

   always #5 clock = ~clock;

   notification_led_pattern_arbiter dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data       (req_data),
      .empty          (empty),
      .pop            (pop),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // predicts every result and compares it against what comes out
   nlpa_result_check result_check (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_data        (req_data),
      .empty           (empty),
      .pop             (pop),
      .rsp_data        (rsp_data),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .drained         (drained),
      .fail_count      (fail_count),
      .results_checked (results_checked),
      .blinks_checked  (blinks_checked)
   );

   // idle length: mostly none or short, now and then long,
   // plus occasional quiet stretches with no idling at all
   function automatic int draw_gap(inout int quiet_left);
      int roll;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         quiet_left = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 50)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type make_update(input logic [1:0] cmd, input logic [31:0] color,
                                           input logic timed, input logic [15:0] on_ms,
                                           input logic [15:0] off_ms);
      req_type u;
      u.cmd         = cmd;
      u.color       = color;
      u.flash_timed = timed;
      u.on_ms       = on_ms;
      u.off_ms      = off_ms;
      return u;
   endfunction

   // random update; dark colours show up often so lower slots get their turn,
   // and on times cluster around the ramp clamp point for the current step
   function automatic req_type random_update();
      req_type u;
      int      roll;
      int      edge_on;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         u.cmd = SLOT_UNUSED;
      else
         u.cmd = 2'($urandom_range(0, 2));
      u.color = $urandom();
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         u.color[23:0] = '0;
      end else if (roll < 40) begin
         case ($urandom_range(0, 3))
            0:       u.color[31:24] = 8'h00;
            1:       u.color[31:24] = ALPHA_FULL;
            2:       u.color[31:24] = 8'h01;
            default: u.color[31:24] = 8'hfe;
         endcase
      end
      u.flash_timed = ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         u.on_ms = '0;
      end else if (roll < 25) begin
         edge_on = 16 * int'(step_now) + int'($urandom_range(0, 2)) - 1;
         if (edge_on < 0)
            edge_on = 0;
         u.on_ms = 16'(edge_on);
      end else if (roll < 55) begin
         u.on_ms = 16'($urandom_range(1, 4200));
      end else begin
         u.on_ms = 16'($urandom());
      end
      roll = $urandom_range(0, 99);
      if (roll < 10)
         u.off_ms = '0;
      else if (roll < 40)
         u.off_ms = 16'($urandom_range(1, 2000));
      else
         u.off_ms = 16'($urandom());
      return u;
   endfunction

   // one update transfer, then an optional gap; push stays high across back-to-back transfers
   task automatic send_update(input req_type item);
      int gap;
      push     <= 1'b1;
      req_data <= item;
      do
         @(posedge clock);
      while (full);
      updates_sent++;
      gap = draw_gap(send_quiet);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until every result so far has been taken
   task automatic wait_for_results();
      while (results_checked != updates_sent)
         @(posedge clock);
   endtask

   task automatic write_step(input logic [7:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      step_now = value;
      settings_count++;
   endtask

   // result side: take results with random stalls between transfers
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         rsp_stall = 0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         pop <= (rsp_stall == 0);
      end else if (pop && !empty) begin
         rsp_stall = draw_gap(rsp_quiet);
         pop <= (rsp_stall == 0);
      end else begin
         pop <= 1'b1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      req_type    directed [$];
      logic [7:0] settings [$];
      logic [7:0] mid_step;
      logic [7:0] any_step;

      // directed updates, all at the reset step of 50 ms (clamp point 800 ms)
      // on time right at the clamp point, then one below it
      directed.push_back(make_update(SLOT_BATTERY, 32'h00ff_ffff, 1'b1, 16'd800, 16'd1000));
      directed.push_back(make_update(SLOT_BATTERY, 32'h00ff_0000, 1'b1, 16'd799, 16'd1));
      directed.push_back(make_update(SLOT_BATTERY, 32'h0000_ff00, 1'b1, 16'hffff, 16'hffff));
      // notification alpha: mid, zero, full, one, just below full
      directed.push_back(make_update(SLOT_NOTIFY, 32'h80ff_8040, 1'b1, 16'd2000, 16'd500));
      directed.push_back(make_update(SLOT_NOTIFY, 32'h0012_3456, 1'b0, 16'd900, 16'd900));
      directed.push_back(make_update(SLOT_NOTIFY, 32'hffff_ffff, 1'b1, 16'd1, 16'hffff));
      directed.push_back(make_update(SLOT_NOTIFY, 32'h01ff_ffff, 1'b1, 16'd4000, 16'd20));
      directed.push_back(make_update(SLOT_NOTIFY, 32'hfe80_8080, 1'b1, 16'd1000, 16'd1000));
      // attention: not timed, on zero, off zero
      directed.push_back(make_update(SLOT_ATTENTION, 32'h0000_0001, 1'b0, 16'd100, 16'd100));
      directed.push_back(make_update(SLOT_ATTENTION, 32'h0000_00ff, 1'b1, 16'd0, 16'd5));
      directed.push_back(make_update(SLOT_ATTENTION, 32'h00ff_00ff, 1'b1, 16'd5, 16'd0));
      // unused slot code leaves the slots alone
      directed.push_back(make_update(SLOT_UNUSED, 32'hffff_ffff, 1'b1, 16'd300, 16'd300));
      // darken slots from the top down until nothing is lit
      directed.push_back(make_update(SLOT_ATTENTION, 32'h0000_0000, 1'b1, 16'd50, 16'd50));
      directed.push_back(make_update(SLOT_NOTIFY, 32'h0100_0080, 1'b1, 16'd60, 16'd60));
      directed.push_back(make_update(SLOT_NOTIFY, 32'h0000_0000, 1'b0, 16'd0, 16'd0));
      directed.push_back(make_update(SLOT_BATTERY, 32'h0000_0000, 1'b1, 16'd10, 16'd10));
      directed.push_back(make_update(SLOT_UNUSED, 32'h0000_0000, 1'b0, 16'd0, 16'd0));
      // dark battery still blinks at white level zero
      directed.push_back(make_update(SLOT_BATTERY, 32'hff00_0000, 1'b1, 16'hffff, 16'hffff));
      directed.push_back(make_update(SLOT_ATTENTION, 32'hffff_ffff, 1'b1, 16'd1, 16'd1));
      directed.push_back(make_update(SLOT_BATTERY, 32'h0001_0101, 1'b1, 16'hffff, 16'd0));

      // step settings: extremes, zero, something in between, reset value, random
      mid_step = 8'($urandom_range(2, 254));
      any_step = 8'($urandom_range(1, 255));
      settings.push_back(8'd1);
      settings.push_back(8'd255);
      settings.push_back(8'd0);
      settings.push_back(mid_step);
      settings.push_back(RAMP_STEP_RESET);
      settings.push_back(any_step);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_update(directed[i]);
      directed_count = directed.size();
      push <= 1'b0;
      wait_for_results();

      // register only changes while nothing is in flight
      foreach (settings[p]) begin
         write_step(settings[p]);
         repeat (UPDATES_PER_SETTING)
            send_update(random_update());
         push <= 1'b0;
         wait_for_results();
      end

      drained <= 1'b1;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d light updates sent (%0d directed) over %0d step settings incl. 0, 1, 255 ms",
               updates_sent, directed_count, settings_count);
      $display("%0d results checked field by field, %0d of them blinking",
               results_checked, blinks_checked);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
